// File: rtl/pbc_pkg.sv
// Shared constants and types for the point versus box contact block.
package pbc_pkg;

	// Default coordinate width in bits (signed Q16.16 at 32).
	localparam int COORD_BITS_DEF = 32;

	// Encodings of one normal component.
	localparam logic signed [1:0] NORM_ZERO = 2'sb00;
	localparam logic signed [1:0] NORM_POS  = 2'sb01;
	localparam logic signed [1:0] NORM_NEG  = 2'sb11;

	// Axis of least overlap.
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

endpackage

// File: rtl/pbc_axis.sv
// Per-axis offset, overlap and saturated face coordinate.
module pbc_axis #(
	parameter int COORD_BITS = pbc_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] pt,
	input  logic signed [COORD_BITS-1:0] bc,
	input  logic        [COORD_BITS-2:0] hs,
	output logic signed [COORD_BITS-1:0] pt_o,
	output logic signed [COORD_BITS+1:0] ov,
	output logic                         neg,
	output logic signed [COORD_BITS-1:0] face
);
	localparam int C = COORD_BITS;

	logic signed [C:0]   delta;
	logic signed [C:0]   face_plus;
	logic signed [C:0]   face_minus;
	logic signed [C:0]   face_raw;
	logic signed [C-1:0] face_sat;
	logic signed [C+1:0] delta_w;
	logic signed [C+1:0] hs_w;

	// The face on the side the point lies; a zero offset counts as positive.
	always_comb begin
		delta      = {pt[C-1], pt} - {bc[C-1], bc};
		face_plus  = {bc[C-1], bc} + {2'b00, hs};
		face_minus = {bc[C-1], bc} - {2'b00, hs};
		face_raw   = delta[C] ? face_minus : face_plus;
		if (face_raw[C] != face_raw[C-1]) begin
			face_sat = face_raw[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
		end else begin
			face_sat = face_raw[C-1:0];
		end
	end

	// Overlap is the half-size less the offset magnitude, one add either way.
	always_comb begin
		delta_w = {delta[C], delta};
		hs_w    = {3'b000, hs};
		ov      = delta[C] ? (hs_w + delta_w) : (hs_w - delta_w);
	end

	assign pt_o = pt;
	assign neg  = delta[C];
	assign face = face_sat;

endmodule

// File: rtl/pbc_select.sv
// Overlap flags, least-overlap axis choice and the registered result.
module pbc_select #(
	parameter int COORD_BITS = pbc_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vld,
	input  logic signed [COORD_BITS-1:0] pt   [3],
	input  logic signed [COORD_BITS+1:0] ov   [3],
	input  logic                         neg  [3],
	input  logic signed [COORD_BITS-1:0] face [3],
	output logic                         done,
	output logic                         touching,
	output logic                         hit,
	output logic signed [COORD_BITS-1:0] contact [3],
	output logic signed [1:0]            normal  [3],
	output logic signed [COORD_BITS-1:0] push    [3]
);
	import pbc_pkg::*;

	localparam int C = COORD_BITS;

	logic                touch_c;
	logic                hit_c;
	axis_t               ax;
	logic signed [C+1:0] ov_neg;
	logic signed [C-1:0] contact_c [3];
	logic signed [1:0]   normal_c  [3];
	logic signed [C-1:0] push_c    [3];
	logic                done_q;
	logic                touch_q;
	logic                hit_q;
	logic signed [C-1:0] contact_q [3];
	logic signed [1:0]   normal_q  [3];
	logic signed [C-1:0] push_q    [3];

	always_comb begin
		touch_c = (ov[0] >= 0) && (ov[1] >= 0) && (ov[2] >= 0);
		hit_c   = (ov[0] > 0) && (ov[1] > 0) && (ov[2] > 0);
		// Any tie for the least overlap selects axis X, even a tie between Y and Z.
		priority if ((ov[2] < ov[0]) && (ov[2] < ov[1])) begin
			ax = AXIS_Z;
		end else if ((ov[1] < ov[0]) && (ov[1] < ov[2])) begin
			ax = AXIS_Y;
		end else begin
			ax = AXIS_X;
		end
		ov_neg = -ov[ax];
		for (int a = 0; a < 3; a++) begin
			contact_c[a] = '0;
			normal_c[a]  = NORM_ZERO;
			push_c[a]    = '0;
			if (hit_c) begin
				contact_c[a] = pt[a];
			end
		end
		if (hit_c) begin
			contact_c[ax] = face[ax];
			normal_c[ax]  = neg[ax] ? NORM_NEG : NORM_POS;
			push_c[ax]    = neg[ax] ? ov_neg[C-1:0] : ov[ax][C-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		touch_q   <= touch_c;
		hit_q     <= hit_c;
		contact_q <= contact_c;
		normal_q  <= normal_c;
		push_q    <= push_c;
	end

	assign done     = done_q;
	assign touching = touch_q;
	assign hit      = hit_q;
	assign contact  = contact_q;
	assign normal   = normal_q;
	assign push     = push_q;

endmodule

// File: rtl/point_box_contact.sv
// Top level of the point versus axis-aligned box contact test.
//
// Each transaction carries a point and a box (centre and half-sizes) in signed
// fixed point and returns one result: an inclusive touching flag, a strict hit
// flag, and on a hit the contact point on the face of least overlap, a unit
// normal and a resolve vector; without a hit every contact, normal and push
// field is zero. The block has one input register and one result register with
// short combinational logic between them (per-axis offset and overlap, then the
// axis choice), and never raises busy, so a transaction may be started in every
// cycle. The result of a transaction accepted at one rising edge is put on the
// result ports with done high at the next rising edge and stays there for
// exactly one cycle; results come out in the order their transactions went in.
// The receiver cannot stall the result; it must take each one in the cycle done
// is high.
module point_box_contact #(
	parameter int COORD_BITS = pbc_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic signed [COORD_BITS-1:0] box_x,
	input  logic signed [COORD_BITS-1:0] box_y,
	input  logic signed [COORD_BITS-1:0] box_z,
	input  logic        [COORD_BITS-2:0] half_x,
	input  logic        [COORD_BITS-2:0] half_y,
	input  logic        [COORD_BITS-2:0] half_z,
	output logic                         done,
	output logic                         touching,
	output logic                         hit,
	output logic signed [COORD_BITS-1:0] contact_x,
	output logic signed [COORD_BITS-1:0] contact_y,
	output logic signed [COORD_BITS-1:0] contact_z,
	output logic signed [1:0]            normal_x,
	output logic signed [1:0]            normal_y,
	output logic signed [1:0]            normal_z,
	output logic signed [COORD_BITS-1:0] push_x,
	output logic signed [COORD_BITS-1:0] push_y,
	output logic signed [COORD_BITS-1:0] push_z
);
	import pbc_pkg::*;

	localparam int C = COORD_BITS;

	// Input register stage. Only the valid bit is reset.
	logic                vld_s1;
	logic signed [C-1:0] pt_s1 [3];
	logic signed [C-1:0] bc_s1 [3];
	logic        [C-2:0] hs_s1 [3];

	// Per-axis results, combinational from the input register.
	logic signed [C-1:0] ax_pt   [3];
	logic signed [C+1:0] ax_ov   [3];
	logic                ax_neg  [3];
	logic signed [C-1:0] ax_face [3];

	logic signed [C-1:0] contact [3];
	logic signed [1:0]   normal  [3];
	logic signed [C-1:0] push    [3];

	// The pipeline never stalls, so a new transaction is taken every cycle.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		pt_s1[0] <= point_x;
		pt_s1[1] <= point_y;
		pt_s1[2] <= point_z;
		bc_s1[0] <= box_x;
		bc_s1[1] <= box_y;
		bc_s1[2] <= box_z;
		hs_s1[0] <= half_x;
		hs_s1[1] <= half_y;
		hs_s1[2] <= half_z;
	end

	// One offset and overlap unit for each axis.
	for (genvar a = 0; a < 3; a++) begin : g_axis
		pbc_axis #(
			.COORD_BITS(C)
		) u_axis (
			.pt   (pt_s1[a]),
			.bc   (bc_s1[a]),
			.hs   (hs_s1[a]),
			.pt_o (ax_pt[a]),
			.ov   (ax_ov[a]),
			.neg  (ax_neg[a]),
			.face (ax_face[a])
		);
	end

	// Flags, axis choice and the result register.
	pbc_select #(
		.COORD_BITS(C)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (vld_s1),
		.pt       (ax_pt),
		.ov       (ax_ov),
		.neg      (ax_neg),
		.face     (ax_face),
		.done     (done),
		.touching (touching),
		.hit      (hit),
		.contact  (contact),
		.normal   (normal),
		.push     (push)
	);

	assign contact_x = contact[0];
	assign contact_y = contact[1];
	assign contact_z = contact[2];
	assign normal_x  = normal[0];
	assign normal_y  = normal[1];
	assign normal_z  = normal[2];
	assign push_x    = push[0];
	assign push_y    = push[1];
	assign push_z    = push[2];

	// A strict hit always implies the point touches the box.
	a_hit_touch: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> touching)
		else $error("hit reported without touching");

	// Without a hit all geometric outputs are zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> contact_x == 0 && contact_y == 0 && contact_z == 0 &&
			normal_x == NORM_ZERO && normal_y == NORM_ZERO && normal_z == NORM_ZERO &&
			push_x == 0 && push_y == 0 && push_z == 0)
		else $error("nonzero contact outputs without a hit");

	// Exactly one normal component is set on a hit.
	a_one_normal: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> $countones({normal_x != NORM_ZERO, normal_y != NORM_ZERO,
			normal_z != NORM_ZERO}) == 1)
		else $error("normal does not name exactly one axis");

	// Every accepted transaction must be followed by its result strobe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result strobe missing after start");

endmodule
